// File: rtl/uialu_pkg.sv
// Package: shared types, operation codes and sequencer states for the ALU.
`default_nettype none
package uialu_pkg;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned REGISTER_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned MODE_W = 5;
  localparam int unsigned CNT_W = 7;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_DIV    = 5'd3,
    OP_MOD    = 5'd4,
    OP_FMA    = 5'd5,
    OP_SQRT   = 5'd6,
    OP_LOG10  = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_AND    = 5'd10,
    OP_OR     = 5'd11,
    OP_XOR    = 5'd12,
    OP_SHL    = 5'd13,
    OP_SHR    = 5'd14,
    OP_ROL    = 5'd15,
    OP_ROR    = 5'd16,
    OP_POPCNT = 5'd17,
    OP_BITLEN = 5'd18
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_ITER,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    reg_idx_t          dest_reg;
    reg_idx_t          src_a_reg;
    reg_idx_t          src_b_reg;
  } instr_t;

  typedef struct packed {
    word_t result_value;
    logic  zero_flag;
    logic  borrow_flag;
    logic  error;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/uialu_if.sv
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface uialu_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/unsigned_integer_alu.sv
// Top level: 64-bit unsigned ALU over a 32-entry register file.
`default_nettype none
// One instruction at a time. An instruction transfer on in_ch reads both
// sources and the destination from the register file (flip-flops, reset to
// zero), then a shared 64-bit add/subtract/shift datapath iterates:
// multiply as 64 shift-and-add steps, divide and modulo as 64 restoring
// subtract steps, square root as 32 steps of one root bit each, log10 as 19
// compare steps against powers of ten, popcount and bit length one bit per
// step. Logic and shift operations take a single step. A result is then
// written back (log10 of zero writes nothing and sets the error flag) and
// offered on out_ch; the next instruction is taken once the result has been
// transferred. The step count is 64 for mul, fma, div, mod, popcount and
// bit length, 32 for sqrt, 19 for log10 (log10 of zero included), 1 for the
// rest.
// Register numbers are REG_IDX_W bits wide, so each one addresses one of the
// REGISTER_COUNT entries.
module unsigned_integer_alu (
  input wire logic clk,
  input wire logic rst,
  uialu_if.sink    in_ch,
  uialu_if.source  out_ch
);
  import uialu_pkg::*;

  state_t state, state_next;
  word_t  rf [REGISTER_COUNT];
  instr_t ins;
  word_t  a, b, d, acc, x, r;
  logic [CNT_W-1:0] cnt;
  logic   zero_bit, borrow_bit, err;
  result_t res;
  op_t    op;

  assign op = op_t'(ins.mode);
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.payload = res;

  // powers of ten, index k gives 10^(k+1)
  function automatic word_t pow10(input logic [4:0] k);
    word_t p;
    case (k)
      5'd0:    p = 64'd10;
      5'd1:    p = 64'd100;
      5'd2:    p = 64'd1000;
      5'd3:    p = 64'd10000;
      5'd4:    p = 64'd100000;
      5'd5:    p = 64'd1000000;
      5'd6:    p = 64'd10000000;
      5'd7:    p = 64'd100000000;
      5'd8:    p = 64'd1000000000;
      5'd9:    p = 64'd10000000000;
      5'd10:   p = 64'd100000000000;
      5'd11:   p = 64'd1000000000000;
      5'd12:   p = 64'd10000000000000;
      5'd13:   p = 64'd100000000000000;
      5'd14:   p = 64'd1000000000000000;
      5'd15:   p = 64'd10000000000000000;
      5'd16:   p = 64'd100000000000000000;
      5'd17:   p = 64'd1000000000000000000;
      5'd18:   p = 64'd10000000000000000000;
      default: p = '1;
    endcase
    return p;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ITER;
      ST_ITER: if (cnt == '0) state_next = ST_DONE;
      ST_DONE: state_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // divide step: shift remainder in acc, quotient bits into x
  logic [DATA_W:0] dsub;
  assign dsub = {1'b0, acc[DATA_W-2:0], x[DATA_W-1]} - {1'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      zero_bit <= 1'b0;
      borrow_bit <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) rf[i] <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_ch.valid) ins <= in_ch.payload;
        ST_READ: begin
          a <= rf[ins.src_a_reg];
          b <= rf[ins.src_b_reg];
          d <= rf[ins.dest_reg];
        end
        ST_LOAD: begin
          acc <= '0;
          r <= '0;
          x <= a;
          err <= 1'b0;
          case (op)
            OP_MUL, OP_FMA, OP_DIV, OP_MOD, OP_POPCNT, OP_BITLEN:
              cnt <= CNT_W'(DATA_W - 1);
            OP_SQRT: cnt <= CNT_W'(DATA_W / 2 - 1);
            OP_LOG10: cnt <= CNT_W'(18);
            default: cnt <= '0;
          endcase
        end
        ST_ITER: begin
          cnt <= cnt - 1'b1;
          case (op)
            OP_MUL, OP_FMA: begin
              acc <= (acc << 1) + (x[DATA_W-1] ? b : '0);
              x <= x << 1;
            end
            OP_DIV, OP_MOD: begin
              if (!dsub[DATA_W] || acc[DATA_W-1]) begin
                acc <= dsub[DATA_W-1:0];
                x <= {x[DATA_W-2:0], 1'b1};
              end else begin
                acc <= {acc[DATA_W-2:0], x[DATA_W-1]};
                x <= {x[DATA_W-2:0], 1'b0};
              end
            end
            OP_SQRT: begin
              // r holds the root bits so far, test (r|bit)^2 <= a via acc
              if (((acc + ((r << ({1'b0, cnt[4:0]} + 6'd1)))
                    + (word_t'(1) << {cnt[4:0], 1'b0})) <= a) &&
                  !(cnt[4:0] == 5'd31 && a[DATA_W-1:DATA_W-2] == 2'b00)) begin
                acc <= acc + (r << ({1'b0, cnt[4:0]} + 6'd1))
                       + (word_t'(1) << {cnt[4:0], 1'b0});
                r <= r | (word_t'(1) << cnt[4:0]);
              end
            end
            OP_LOG10: if (a >= pow10(cnt[4:0]) && r == '0) r <= word_t'(cnt) + 1'b1;
            OP_POPCNT: begin
              r <= r + word_t'(x[0]);
              x <= x >> 1;
            end
            OP_BITLEN: begin
              if (x[0]) r <= word_t'(CNT_W'(DATA_W) - cnt);
              x <= x >> 1;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          logic        wr_en, setz;
          word_t       v;
          logic  [5:0] sh;
          sh = b[5:0];
          wr_en = 1'b1;
          setz = 1'b1;
          v = '0;
          case (op)
            OP_ADD: begin v = a + b; setz = 1'b0; end
            OP_SUB: begin v = a - b; borrow_bit <= (a < b); end
            OP_MUL: begin v = acc; setz = 1'b0; end
            OP_FMA: begin v = d + acc; setz = 1'b0; end
            OP_DIV: begin borrow_bit <= (b == '0); v = (b == '0) ? '0 : x; end
            OP_MOD: begin borrow_bit <= (b == '0); v = (b == '0) ? '0 : acc; end
            OP_SQRT: v = r;
            OP_LOG10: begin
              if (a == '0) begin
                wr_en = 1'b0; setz = 1'b0; err <= 1'b1;
              end else v = r;
            end
            OP_INC: begin v = d + 1'b1; setz = 1'b0; end
            OP_DEC: begin borrow_bit <= (d == '0); v = d - 1'b1; end
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_SHL: v = a << sh;
            OP_SHR: v = a >> sh;
            OP_ROL: v = (a << sh) | (a >> (7'd64 - {1'b0, sh}));
            OP_ROR: v = (a >> sh) | (a << (7'd64 - {1'b0, sh}));
            OP_POPCNT: v = r;
            OP_BITLEN: v = r;
            default: begin wr_en = 1'b0; setz = 1'b0; end
          endcase
          if (setz) zero_bit <= (v == '0);
          if (wr_en) rf[ins.dest_reg] <= v;
          d <= wr_en ? v : d;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.result_value = d;
    res.zero_flag = zero_bit;
    res.borrow_flag = borrow_bit;
    res.error = err;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("result changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second take");
`endif
endmodule
`default_nettype wire
